// ----- rtl/foldback_output_limiter_unit_assert.svh -----
// Assertion macros used by the foldback limiter checker.
`ifndef FOLDBACK_OUTPUT_LIMITER_UNIT_ASSERT_SVH
`define FOLDBACK_OUTPUT_LIMITER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("foldback limiter check failed");

// Consequent must hold a fixed number of cycles after the antecedent.
`define FL_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error("foldback limiter check failed");

`endif

// ----- rtl/foldlim_pkg.sv -----
// Shared types and constants of the foldback output limiter.
package foldlim_pkg;

	localparam int FL_DATA_WIDTH = 16;
	localparam int FL_LIMIT_W    = 15;
	localparam int FL_QUOT_BITS  = FL_LIMIT_W;
	localparam int FL_CFG_IDX_W  = 3;
	// input register, window stage, multiplier, divider cells, limit stage, output stage
	localparam int FL_LATENCY    = 3 + FL_QUOT_BITS + 2;

	typedef enum logic [FL_CFG_IDX_W-1:0] {
		CFG_ENABLE       = 3'd0,
		CFG_TRIM_MODE    = 3'd1,
		CFG_INVERTED     = 3'd2,
		CFG_END_VALUE    = 3'd3,
		CFG_WINDOW_WIDTH = 3'd4,
		CFG_LIMIT_HIGH   = 3'd5,
		CFG_LIMIT_LOW    = 3'd6
	} cfg_idx_t;

	// Control that travels alongside each beat through the divider chain.
	typedef struct packed {
		logic valid;
		logic in_win;   // control value lies strictly inside the window
		logic hi;       // outside the window on the high-limit side
		logic neg;      // limit span is negative: limit_low lies above limit_high
	} fl_ctl_t;

endpackage

// ----- rtl/foldlim_cell.sv -----
// One restoring-division step of the derating ramp, with its pipeline register.
module foldlim_cell
	import foldlim_pkg::*;
#(
	parameter int DATA_WIDTH = FL_DATA_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [DATA_WIDTH-1:0]   divisor,
	input  fl_ctl_t                 ctl_in,
	input  logic [DATA_WIDTH-1:0]   x_in,
	input  logic [DATA_WIDTH-1:0]   rem_in,
	input  logic [FL_QUOT_BITS-1:0] nq_in,
	output fl_ctl_t                 ctl_out,
	output logic [DATA_WIDTH-1:0]   x_out,
	output logic [DATA_WIDTH-1:0]   rem_out,
	output logic [FL_QUOT_BITS-1:0] nq_out
);

	fl_ctl_t                 ctl_q;
	logic [DATA_WIDTH-1:0]   x_q;
	logic [DATA_WIDTH-1:0]   rem_q;
	logic [FL_QUOT_BITS-1:0] nq_q;

	logic [DATA_WIDTH:0]     trial;
	logic [DATA_WIDTH:0]     diff;
	logic                    fits;

	// Shift the next numerator bit in; subtract when the divisor fits.
	assign trial = {rem_in, nq_in[FL_QUOT_BITS-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		x_q   <= x_in;
		rem_q <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
		nq_q  <= {nq_in[FL_QUOT_BITS-2:0], fits};
	end

	assign ctl_out = ctl_q;
	assign x_out   = x_q;
	assign rem_out = rem_q;
	assign nq_out  = nq_q;

endmodule

// ----- rtl/foldback_output_limiter_unit.sv -----
// Top level of the foldback output limiter: config registers, window logic, divider chain.
//
// Foldback output limiter. Pulse start with an input_value and a control_value;
// the block never stalls, so busy stays low and a new beat may be started on
// every clock. Each beat returns exactly one output_value, marked by a single
// cycle of done, in the order the beats were started. The receiver cannot
// hold results off: take output_value on the cycle done is high. The pipeline
// is the ramp division, a row of 15 restoring-division cells (one quotient
// bit each), after an input register, a window-decode stage and a multiplier
// stage, followed by two stages that form the limit and clamp the input.
// Configuration is written through cfg_we / cfg_index / cfg_wdata; write it
// only while no beat is in flight. Writes to an index beyond the last
// register are dropped. There is no stored state between beats.
module foldback_output_limiter_unit
	import foldlim_pkg::*;
#(
	parameter int DATA_WIDTH = FL_DATA_WIDTH
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	output logic                                         busy,
	input  logic signed [DATA_WIDTH-1:0]                 input_value,
	input  logic signed [DATA_WIDTH-1:0]                 control_value,
	output logic                                         done,
	output logic signed [DATA_WIDTH-1:0]                 output_value,
	input  logic                                         cfg_we,
	input  logic [FL_CFG_IDX_W-1:0]                      cfg_index,
	input  logic [((DATA_WIDTH > FL_LIMIT_W) ? DATA_WIDTH : FL_LIMIT_W)-1:0] cfg_wdata
);

	localparam int W  = DATA_WIDTH;
	// width for handling the 16-bit limit values next to the data width
	localparam int MW = (W > 16) ? W : 16;
	// width for the window start before saturation
	localparam int SW = MW + 2;
	localparam int PW = W + FL_QUOT_BITS;

	localparam logic [MW-1:0]        DW_MAX_M = MW'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [SW-1:0] DW_MAX_S = SW'($signed({1'b0, {(W-1){1'b1}}}));
	localparam logic signed [SW-1:0] DW_MIN_S = SW'($signed({1'b1, {(W-1){1'b0}}}));

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic                  enable_q;
	logic                  trim_q;
	logic                  inverted_q;
	logic signed [W-1:0]   end_q;
	logic [FL_LIMIT_W-1:0] width_q;
	logic [FL_LIMIT_W-1:0] high_q;
	logic [FL_LIMIT_W-1:0] low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			trim_q     <= 1'b1;
			inverted_q <= 1'b0;
			end_q      <= '0;
			width_q    <= '0;
			high_q     <= '1;
			low_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ENABLE:       enable_q   <= cfg_wdata[0];
				CFG_TRIM_MODE:    trim_q     <= cfg_wdata[0];
				CFG_INVERTED:     inverted_q <= cfg_wdata[0];
				CFG_END_VALUE:    end_q      <= cfg_wdata[W-1:0];
				CFG_WINDOW_WIDTH: width_q    <= cfg_wdata[FL_LIMIT_W-1:0];
				CFG_LIMIT_HIGH:   high_q     <= cfg_wdata[FL_LIMIT_W-1:0];
				CFG_LIMIT_LOW:    low_q      <= cfg_wdata[FL_LIMIT_W-1:0];
				default: ;        // drop writes to unused indexes
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Window geometry, derived from the configuration
	// start_q is registered from the configuration, divisor_q from start_q; the
	// divisor is first used by the cells well after any beat started behind a write.
	// ------------------------------------------------------------------
	logic signed [SW-1:0] start_sum;
	logic signed [W-1:0]  start_q;
	logic [W-1:0]         divisor_q;
	logic [W:0]           div_full;

	always_comb begin
		if (inverted_q) begin
			start_sum = SW'(end_q) + $signed(SW'(width_q));
		end else begin
			start_sum = SW'(end_q) - $signed(SW'(width_q));
		end
	end

	assign div_full = (start_q > end_q) ? ({start_q[W-1], start_q} - {end_q[W-1], end_q})
	                                    : ({end_q[W-1], end_q} - {start_q[W-1], start_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			divisor_q <= '0;
		end else begin
			// saturate the window start to the data range
			priority if (start_sum > DW_MAX_S) begin
				start_q <= DW_MAX_S[W-1:0];
			end else if (start_sum < DW_MIN_S) begin
				start_q <= DW_MIN_S[W-1:0];
			end else begin
				start_q <= start_sum[W-1:0];
			end
			divisor_q <= div_full[W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: register the accepted beat
	// ------------------------------------------------------------------
	logic                valid_s1;
	logic signed [W-1:0] x_s1;
	logic signed [W-1:0] c_s1;

	assign busy = 1'b0;   // one beat per cycle, never stalls

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= input_value;
		c_s1 <= control_value;
	end

	// ------------------------------------------------------------------
	// Stage 2: place the control value against the window
	// The window counts as inverted only when the saturated start lies above
	// the end value, so a zero width always behaves as a normal window.
	// ------------------------------------------------------------------
	logic                  inv_eff;
	logic                  c_gt_start;
	logic                  c_lt_start;
	logic                  c_gt_end;
	logic                  c_lt_end;
	logic [W:0]            dc_full;
	logic [FL_LIMIT_W:0]   dh_full;
	fl_ctl_t               ctl_s2;
	logic [W-1:0]          x_s2;
	logic [W-1:0]          dc_s2;
	logic [FL_LIMIT_W-1:0] dh_s2;

	assign inv_eff    = start_q > end_q;
	assign c_gt_start = c_s1 > start_q;
	assign c_lt_start = c_s1 < start_q;
	assign c_gt_end   = c_s1 > end_q;
	assign c_lt_end   = c_s1 < end_q;
	assign dc_full    = inv_eff ? ({c_s1[W-1], c_s1} - {end_q[W-1], end_q})
	                            : ({end_q[W-1], end_q} - {c_s1[W-1], c_s1});
	assign dh_full    = {1'b0, high_q} - {1'b0, low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2.valid  <= valid_s1;
			ctl_s2.in_win <= inv_eff ? (c_lt_start && c_gt_end) : (c_gt_start && c_lt_end);
			ctl_s2.hi     <= inv_eff ? !c_lt_start : !c_gt_start;
			ctl_s2.neg    <= dh_full[FL_LIMIT_W];
		end
	end

	always_ff @(posedge clk) begin
		x_s2  <= x_s1;
		// inside the window the distance is below the divisor, so W bits hold it
		dc_s2 <= dc_full[W-1:0];
		// magnitude of the limit span
		dh_s2 <= dh_full[FL_LIMIT_W] ? FL_LIMIT_W'(-dh_full) : dh_full[FL_LIMIT_W-1:0];
	end

	// ------------------------------------------------------------------
	// Stage 3: span times distance; the product is below divisor * 2^15,
	// so its upper W bits are already a valid partial remainder
	// ------------------------------------------------------------------
	fl_ctl_t       ctl_s3;
	logic [W-1:0]  x_s3;
	logic [PW-1:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s3    <= x_s2;
		prod_s3 <= PW'(dh_s2) * PW'(dc_s2);
	end

	// ------------------------------------------------------------------
	// Divider chain: one quotient bit per cell, handed on every cycle
	// ------------------------------------------------------------------
	fl_ctl_t                 ctl_c [0:FL_QUOT_BITS];
	logic [W-1:0]            x_c   [0:FL_QUOT_BITS];
	logic [W-1:0]            rem_c [0:FL_QUOT_BITS];
	logic [FL_QUOT_BITS-1:0] nq_c  [0:FL_QUOT_BITS];

	assign ctl_c[0] = ctl_s3;
	assign x_c[0]   = x_s3;
	assign rem_c[0] = prod_s3[PW-1:FL_QUOT_BITS];
	assign nq_c[0]  = prod_s3[FL_QUOT_BITS-1:0];

	for (genvar k = 0; k < FL_QUOT_BITS; k++) begin : g_cell
		foldlim_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.divisor (divisor_q),
			.ctl_in  (ctl_c[k]),
			.x_in    (x_c[k]),
			.rem_in  (rem_c[k]),
			.nq_in   (nq_c[k]),
			.ctl_out (ctl_c[k+1]),
			.x_out   (x_c[k+1]),
			.rem_out (rem_c[k+1]),
			.nq_out  (nq_c[k+1])
		);
	end

	// ------------------------------------------------------------------
	// Stage 4: form the limit (quotient truncated toward zero, signed by the
	// span direction, plus limit_low), then saturate to the data range
	// ------------------------------------------------------------------
	logic [FL_QUOT_BITS-1:0] quot;
	logic [FL_LIMIT_W+1:0]   quot_signed;
	logic [FL_LIMIT_W+1:0]   ramp;
	logic [15:0]             lim16;
	logic [MW-1:0]           lim_ext;
	logic                    valid_s4;
	logic [W-1:0]            x_s4;
	logic [W-1:0]            lim_s4;

	assign quot        = nq_c[FL_QUOT_BITS];
	assign quot_signed = ctl_c[FL_QUOT_BITS].neg ? (FL_LIMIT_W+2)'(-{2'b00, quot})
	                                             : {2'b00, quot};
	assign ramp        = quot_signed + {2'b00, low_q};

	always_comb begin
		priority if (ctl_c[FL_QUOT_BITS].in_win) begin
			lim16 = ramp[15:0];
		end else if (ctl_c[FL_QUOT_BITS].hi) begin
			lim16 = {1'b0, high_q};
		end else begin
			lim16 = {1'b0, low_q};
		end
		lim_ext = MW'(lim16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= ctl_c[FL_QUOT_BITS].valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s4   <= x_c[FL_QUOT_BITS];
		lim_s4 <= (lim_ext > DW_MAX_M) ? DW_MAX_M[W-1:0] : lim_ext[W-1:0];
	end

	// ------------------------------------------------------------------
	// Stage 5: pass through, output the limit, or clamp to +/- limit
	// ------------------------------------------------------------------
	logic signed [W:0]   x_ext;
	logic signed [W:0]   lim_pos;
	logic signed [W:0]   lim_neg;
	logic signed [W-1:0] y;
	logic                valid_s5;
	logic signed [W-1:0] out_s5;

	assign x_ext   = {x_s4[W-1], x_s4};
	assign lim_pos = {1'b0, lim_s4};
	assign lim_neg = -lim_pos;

	always_comb begin
		priority if (!enable_q) begin
			y = x_s4;
		end else if (!trim_q) begin
			y = lim_s4;
		end else if (x_ext > lim_pos) begin
			y = lim_s4;
		end else if (x_ext < lim_neg) begin
			y = lim_neg[W-1:0];
		end else begin
			y = x_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		out_s5 <= y;
	end

	assign done         = valid_s5;
	assign output_value = out_s5;

endmodule

// ----- rtl/foldlim_checker.sv -----
// Port-level checker for the foldback output limiter, bound to the top level.
module foldlim_checker
	import foldlim_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

`include "foldback_output_limiter_unit_assert.svh"

	// every taken beat comes back after the fixed latency
	`FL_ASSERT_DELAY(a_beat_returns, clk, arst_n, start && !busy, FL_LATENCY, done)
	// no result beat without a beat taken the latency earlier
	`FL_ASSERT_NOW(a_beat_has_cause, clk, arst_n, done, $past(start && !busy && arst_n, FL_LATENCY))
	// the block never holds off a start
	`FL_ASSERT_NOW(a_never_busy, clk, arst_n, start, !busy)

endmodule

bind foldback_output_limiter_unit foldlim_checker u_foldlim_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
